[rtl/core/msb_first_bit_packer_defines.svh]
// ------------------------------------------------------------------------
// msb_first_bit_packer_defines: assertion macros
// shared shorthand for the concurrent checks on the packer ports
// ------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define MFBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mfbp same-cycle check failed");

// next-cycle implication, disabled while reset is active
`define MFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mfbp next-cycle check failed");

`endif

[rtl/core/mfbp_pkg.sv]
// ------------------------------------------------------------------------
// mfbp_pkg
// types and constants shared by the msb-first bit packer modules
// ------------------------------------------------------------------------
package mfbp_pkg;

	localparam int MAX_CODE_BITS_DEF = 32;
	localparam int VALUE_W           = 32;
	localparam int LEN_W             = 6;
	localparam int BYTE_W            = 8;
	localparam int QDEPTH            = 2;
	localparam int QPTR_W            = 1;
	localparam int QCNT_W            = 2;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_FLUSH = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	// one queued run: up to four bytes, first byte in data[0]
	typedef struct packed {
		logic [3:0][BYTE_W-1:0] data;
		logic [1:0]             last_idx;
	} mfbp_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mfbp_qstat_t;

endpackage

[rtl/core/mfbp_front.sv]
// ------------------------------------------------------------------------
// mfbp_front
// accepts requests, merges code bits into the partial byte, and queues
// the bytes each transaction completes
// ------------------------------------------------------------------------
module mfbp_front #(
	parameter int MAX_CODE_BITS = mfbp_pkg::MAX_CODE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [39:0]               s_axis_tdata,
	input  logic [7:0]                s_axis_tuser,
	input  mfbp_pkg::mfbp_qstat_t     qstat,
	output logic                      push,
	output mfbp_pkg::mfbp_entry_t     push_entry
);

	localparam int LenLimit = (MAX_CODE_BITS > mfbp_pkg::VALUE_W) ?
		mfbp_pkg::VALUE_W : MAX_CODE_BITS;

	logic [7:0] partial_q;
	logic [2:0] fill_q;

	logic                       accept;
	mfbp_pkg::req_t             req;
	logic [31:0]                value;
	logic [5:0]                 len_in;
	logic [5:0]                 len_sat;
	logic [39:0]                mask_w;
	logic [39:0]                vext;
	logic [5:0]                 sh;
	logic [39:0]                word;
	logic [5:0]                 total;
	logic [2:0]                 nbytes;
	logic [7:0]                 partial_d;
	logic [2:0]                 fill_d;

	assign s_axis_tready = !qstat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign req           = mfbp_pkg::req_t'(s_axis_tuser[1:0]);
	assign value         = s_axis_tdata[31:0];
	assign len_in        = s_axis_tdata[37:32];

	always_comb begin
		len_sat = (len_in > 6'(LenLimit)) ? 6'(LenLimit) : len_in;
		mask_w  = (40'd1 << len_sat) - 40'd1;
		vext    = {8'd0, value} & mask_w;
		sh      = 6'd40 - {3'd0, fill_q} - len_sat;
		// pending bits sit on top, new code right below them
		word    = {partial_q, 32'd0} | (vext << sh);
		total   = {3'd0, fill_q} + len_sat;
		nbytes  = total[5:3];
	end

	always_comb begin
		push       = 1'b0;
		push_entry = '0;
		partial_d  = partial_q;
		fill_d     = fill_q;
		unique case (req)
			mfbp_pkg::REQ_WRITE: begin
				push                = (nbytes != 3'd0);
				push_entry.last_idx = 2'(nbytes - 3'd1);
				for (int k = 0; k < 4; k++) begin
					push_entry.data[k] = word[39-8*k -: 8];
				end
				fill_d = total[2:0];
				case (nbytes)
					3'd0:    partial_d = word[39:32];
					3'd1:    partial_d = word[31:24];
					3'd2:    partial_d = word[23:16];
					3'd3:    partial_d = word[15:8];
					default: partial_d = word[7:0];
				endcase
			end
			mfbp_pkg::REQ_FLUSH: begin
				push                = (fill_q != 3'd0);
				push_entry.data[0]  = partial_q;
				push_entry.last_idx = 2'd0;
				partial_d           = 8'd0;
				fill_d              = 3'd0;
			end
			mfbp_pkg::REQ_CLEAR: begin
				partial_d = 8'd0;
				fill_d    = 3'd0;
			end
			default: begin
			end
		endcase
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= 8'd0;
			fill_q    <= 3'd0;
		end else if (accept) begin
			partial_q <= partial_d;
			fill_q    <= fill_d;
		end
	end

endmodule

[rtl/core/mfbp_fifo.sv]
// ------------------------------------------------------------------------
// mfbp_fifo
// two-entry run queue between the front and the back
// ------------------------------------------------------------------------
module mfbp_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mfbp_pkg::mfbp_entry_t push_entry,
	input  logic                  pop,
	output mfbp_pkg::mfbp_entry_t head,
	output mfbp_pkg::mfbp_qstat_t qstat
);

	mfbp_pkg::mfbp_entry_t mem [mfbp_pkg::QDEPTH];

	logic [mfbp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [mfbp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [mfbp_pkg::QCNT_W-1:0] cnt_q;

	assign qstat.full  = (cnt_q == mfbp_pkg::QCNT_W'(mfbp_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/mfbp_back.sv]
// ------------------------------------------------------------------------
// mfbp_back
// streams the bytes of the head run one per transaction, marking the last
// ------------------------------------------------------------------------
module mfbp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mfbp_pkg::mfbp_entry_t head,
	input  mfbp_pkg::mfbp_qstat_t qstat,
	output logic                  pop,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,
	output logic                  m_axis_tlast
);

	logic [1:0] idx_q;
	logic       take;

	assign m_axis_tvalid = !qstat.empty;
	assign m_axis_tdata  = head.data[idx_q];
	assign m_axis_tlast  = (idx_q == head.last_idx);
	assign take          = m_axis_tvalid && m_axis_tready;
	assign pop           = take && m_axis_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= m_axis_tlast ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

[rtl/core/msb_first_bit_packer.sv]
// ------------------------------------------------------------------------
// msb_first_bit_packer
// variable-length bit packer, msb first, byte stream out
// ------------------------------------------------------------------------
// channel  dir  tdata                                   tuser          tlast
// s_axis   in   [31:0] code_value, [37:32] code_length  [1:0] req_type -
// m_axis   out  [7:0] packed_byte                       -              run_last
//
// one request per cycle while the run queue is not full; the front merges bits and queues a run
// output gives one byte per cycle while m_axis_tready is high; a run stays at the queue head until its last byte
// is taken. s_axis_tready drops only while the two-entry run queue is full
// arst_n clears the partial byte, fill count and queue pointers
// ------------------------------------------------------------------------
module msb_first_bit_packer #(
	parameter int MAX_CODE_BITS = mfbp_pkg::MAX_CODE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] code_value, [37:32] code_length
	input  logic [7:0]  s_axis_tuser,  // [1:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] packed_byte
	output logic        m_axis_tlast
);

	mfbp_pkg::mfbp_qstat_t qstat;
	mfbp_pkg::mfbp_entry_t push_entry;
	mfbp_pkg::mfbp_entry_t head;
	logic                  push;
	logic                  pop;

	mfbp_front #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.qstat        (qstat),
		.push         (push),
		.push_entry   (push_entry)
	);

	mfbp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	mfbp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

[rtl/core/mfbp_checker.sv]
// ------------------------------------------------------------------------
// mfbp_checker
// port-level checks on the packer, bound to the top level
// ------------------------------------------------------------------------
`include "msb_first_bit_packer_defines.svh"

module mfbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast
);

	logic [1:0] run_cnt_q;
	logic       seen_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= 2'd0;
			seen_q    <= 1'b0;
		end else begin
			if (in_xfer) begin
				seen_q <= 1'b1;
			end
			if (out_xfer) begin
				run_cnt_q <= m_axis_tlast ? 2'd0 : run_cnt_q + 2'd1;
			end
		end
	end

	// a stalled output byte holds
	`MFBP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	// no request produces more than four bytes
	`MFBP_ASSERT_IMPLY(a_run_max4, clk, arst_n, out_xfer && (run_cnt_q == 2'd3), m_axis_tlast)
	// no byte comes out before any request went in
	`MFBP_ASSERT_IMPLY(a_no_spurious, clk, arst_n, m_axis_tvalid, seen_q)
	// with nothing queued the input side is open
	`MFBP_ASSERT_IMPLY(a_ready_idle, clk, arst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind msb_first_bit_packer mfbp_checker u_chk (.*);
